[design/cpw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cpw_pkg
// Shared widths, register codes and types of the clipped alpha pixel writer.
// -----------------------------------------------------------------------------
package cpw_pkg;

   localparam int MAX_SIDE_DEF    = 1024;
   localparam int STORE_DEPTH_DEF = 1048576;

   localparam int POS_W      = 16;   // signed pixel coordinate
   localparam int COORD_W    = POS_W - 1;  // magnitude of a non-negative coordinate
   localparam int COLOR_W    = 32;
   localparam int CFG_W      = 11;   // width of every configuration register
   localparam int PIX_ADDR_W = 20;   // reported address width
   localparam int PROD_W     = COORD_W + CFG_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd2;

   localparam logic MODE_OPAQUE = 1'b0;
   localparam logic MODE_BLEND  = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
      logic [CFG_W-1:0] row_stride;
   } cfg_type;

endpackage
`default_nettype wire

[design/cpw_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cpw_if
// Valid/ready channels for pixel commands and pixel write reports.
// -----------------------------------------------------------------------------
interface cpw_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic signed [cpw_pkg::POS_W-1:0]  pos_x;
   logic signed [cpw_pkg::POS_W-1:0]  pos_y;
   logic [cpw_pkg::COLOR_W-1:0]       color;

   modport source (output valid, mode, pos_x, pos_y, color, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, color, output ready);
endinterface

interface cpw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              written;
   logic [cpw_pkg::PIX_ADDR_W-1:0]    pixel_address;
   logic [cpw_pkg::COLOR_W-1:0]       stored_value;

   modport source (output valid, written, pixel_address, stored_value, input ready);
   modport sink   (input valid, written, pixel_address, stored_value, output ready);
endinterface
`default_nettype wire

[design/cpw_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cpw_csr
// APB-style register file: frame width, frame height and row stride.
// -----------------------------------------------------------------------------
module cpw_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cpw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [cpw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [cpw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output cpw_pkg::cfg_type                     cfg
);

   cpw_pkg::cfg_type                 cfg_ff;
   cpw_pkg::cfg_type                 cfg_in;
   logic [cpw_pkg::REG_IDX_W-1:0]    reg_idx;
   logic [cpw_pkg::CFG_W-1:0]        wr_val;
   logic                             wr_fire;

   assign pready  = 1'b1;
   assign reg_idx = paddr[cpw_pkg::CSR_ADDR_W-1:2];
   assign wr_val  = pwdata[cpw_pkg::CFG_W-1:0];
   assign wr_fire = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            cpw_pkg::REG_FRAME_WIDTH:  cfg_in.frame_width  = wr_val;
            cpw_pkg::REG_FRAME_HEIGHT: cfg_in.frame_height = wr_val;
            cpw_pkg::REG_ROW_STRIDE:   cfg_in.row_stride   = wr_val;
            default:                   cfg_in = cfg_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= cpw_pkg::CFG_RESET;
         cfg_ff.frame_height <= cpw_pkg::CFG_RESET;
         cfg_ff.row_stride   <= cpw_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         cpw_pkg::REG_FRAME_WIDTH:
            prdata = cpw_pkg::CSR_DATA_W'(cfg_ff.frame_width);
         cpw_pkg::REG_FRAME_HEIGHT:
            prdata = cpw_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         cpw_pkg::REG_ROW_STRIDE:
            prdata = cpw_pkg::CSR_DATA_W'(cfg_ff.row_stride);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[design/cpw_pixel_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cpw_pixel_ram
// Single-port-write, single-port-read pixel memory with registered read data.
// -----------------------------------------------------------------------------
module cpw_pixel_ram #(
   parameter int DEPTH  = cpw_pkg::STORE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [ADDR_W-1:0]            wr_addr,
   input  wire logic [cpw_pkg::COLOR_W-1:0]  wr_data,
   input  wire logic                         rd_en,
   input  wire logic [ADDR_W-1:0]            rd_addr,
   output logic      [cpw_pkg::COLOR_W-1:0]  rd_data
);

   logic [cpw_pkg::COLOR_W-1:0] mem [DEPTH];
   logic [cpw_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/cpw_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cpw_blend
// Per-channel alpha mix: registered products, then sum and divide by 255.
// -----------------------------------------------------------------------------
module cpw_blend (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic [cpw_pkg::COLOR_W-1:0]  old_pixel,
   input  wire logic [cpw_pkg::COLOR_W-1:0]  color,
   output logic      [cpw_pkg::COLOR_W-1:0]  mixed
);

   localparam int PW = 2 * cpw_pkg::CHAN_W;

   logic [PW-1:0]               p_old_ff [cpw_pkg::NUM_CHAN];
   logic [PW-1:0]               p_new_ff [cpw_pkg::NUM_CHAN];
   logic [cpw_pkg::CHAN_W-1:0]  alpha;
   logic [cpw_pkg::CHAN_W-1:0]  inv_alpha;
   logic [cpw_pkg::CHAN_W-1:0]  quot [cpw_pkg::NUM_CHAN];

   assign alpha     = color[cpw_pkg::COLOR_W-1 -: cpw_pkg::CHAN_W];
   assign inv_alpha = ~alpha;  // 255 - a

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < cpw_pkg::NUM_CHAN; c++) begin
            p_old_ff[c] <= PW'(old_pixel[c*cpw_pkg::CHAN_W +: cpw_pkg::CHAN_W])
                         * PW'(inv_alpha);
            p_new_ff[c] <= PW'(color[c*cpw_pkg::CHAN_W +: cpw_pkg::CHAN_W])
                         * PW'(alpha);
         end
      end
   end

   // Sum is at most 255*255, where (s + (s >> 8) + 1) >> 8 equals s / 255.
   always_comb begin
      logic [PW:0] s;
      logic [PW:0] t;
      for (int c = 0; c < cpw_pkg::NUM_CHAN; c++) begin
         s       = {1'b0, p_old_ff[c]} + {1'b0, p_new_ff[c]};
         t       = s + (s >> cpw_pkg::CHAN_W) + (PW+1)'(1);
         quot[c] = t[PW-1:cpw_pkg::CHAN_W];
      end
   end

   assign mixed = {{cpw_pkg::CHAN_W{1'b0}}, quot[2], quot[1], quot[0]};

endmodule
`default_nettype wire

[design/clipped_alpha_pixel_writer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// clipped_alpha_pixel_writer_top
// Clips pixel commands, writes or alpha-blends them into the pixel memory.
// -----------------------------------------------------------------------------
// After reset the block sweeps the whole pixel memory to zero, one word per
// clock, so it accepts no command until every word is cleared (register
// writes are taken during the sweep). Then it handles one command at a time:
// an opaque write or a clipped pixel passes through MUL, ADDR and DONE before
// its report is posted; an alpha blend also passes through READ, the memory
// read, and MIX, the registered channel products, between ADDR and DONE. A new
// command is accepted only in idle, after the last one's report is posted.
// The single-command sequencer below owns the memory read and write
// ports.
// The report is held in an output register, so the next command is accepted
// while an earlier report still waits on rsp_port; that command then holds in
// its last step until the slot frees. A clipped pixel, including one whose
// address falls past the memory, stores nothing and reports all zero.
// Registers: frame_width at 0x0, frame_height at 0x4, row_stride at 0x8;
// only bits 10:0 kept; paddr[1:0] ignored; writes at 0xC-0xF are dropped.
// -----------------------------------------------------------------------------
module clipped_alpha_pixel_writer_top #(
   parameter int MAX_SIDE    = cpw_pkg::MAX_SIDE_DEF,
   parameter int STORE_DEPTH = cpw_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cpw_req_if.sink                              req_port,
   cpw_rsp_if.source                            rsp_port,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cpw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [cpw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [cpw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;  // zero sweep after reset
   localparam logic [2:0] ST_IDLE  = 3'd1;  // wait for a command
   localparam logic [2:0] ST_MUL   = 3'd2;  // clip check, row times stride
   localparam logic [2:0] ST_ADDR  = 3'd3;  // add column, range check
   localparam logic [2:0] ST_READ  = 3'd4;  // read stored pixel
   localparam logic [2:0] ST_MIX   = 3'd5;  // register channel products
   localparam logic [2:0] ST_DONE  = 3'd6;  // write back, post report

   cpw_pkg::cfg_type                 cfg;

   logic [2:0]                       state_ff, state_in;
   logic [ADDR_W-1:0]                clr_cnt_ff, clr_cnt_in;

   // Command registers
   logic                             mode_ff;
   logic signed [cpw_pkg::POS_W-1:0] x_ff, y_ff;
   logic [cpw_pkg::COLOR_W-1:0]      color_ff;

   logic [cpw_pkg::PROD_W-1:0]       prod_ff;
   logic                             clip_ok_ff;
   logic [cpw_pkg::SUM_W-1:0]        addr_ff;
   logic                             inside_ff;

   // Report register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_written_ff;
   logic [cpw_pkg::PIX_ADDR_W-1:0]   rsp_addr_ff;
   logic [cpw_pkg::COLOR_W-1:0]      rsp_value_ff;

   logic [cpw_pkg::COORD_W-1:0]      x_mag, y_mag;
   logic                             clip_ok;
   logic [cpw_pkg::SUM_W-1:0]        addr_sum;
   logic                             in_store;
   logic                             accept;
   logic                             out_free;
   logic                             finish;
   logic [cpw_pkg::COLOR_W-1:0]      old_pixel;
   logic [cpw_pkg::COLOR_W-1:0]      mixed;
   logic [cpw_pkg::COLOR_W-1:0]      new_value;

   logic                             mem_wr_en;
   logic [ADDR_W-1:0]                mem_wr_addr;
   logic [cpw_pkg::COLOR_W-1:0]      mem_wr_data;
   logic                             mem_rd_en;

   cpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cpw_pixel_ram #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (old_pixel)
   );

   cpw_blend u_blend (
      .clock     (clock),
      .load      (state_ff == ST_MIX),
      .old_pixel (old_pixel),
      .color     (color_ff),
      .mixed     (mixed)
   );

   // Take a command only in idle; the report slot is checked at the end.
   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign finish         = (state_ff == ST_DONE) && out_free;

   // Clip: non-negative, below the frame size and below MAX_SIDE.
   assign x_mag   = x_ff[cpw_pkg::COORD_W-1:0];
   assign y_mag   = y_ff[cpw_pkg::COORD_W-1:0];
   assign clip_ok = !x_ff[cpw_pkg::POS_W-1] && !y_ff[cpw_pkg::POS_W-1]
                 && (x_mag < cpw_pkg::COORD_W'(cfg.frame_width))
                 && (y_mag < cpw_pkg::COORD_W'(cfg.frame_height))
                 && (x_mag < cpw_pkg::COORD_W'(MAX_SIDE))
                 && (y_mag < cpw_pkg::COORD_W'(MAX_SIDE));

   assign addr_sum = cpw_pkg::SUM_W'(prod_ff) + cpw_pkg::SUM_W'(x_mag);
   assign in_store = clip_ok_ff && (addr_sum < cpw_pkg::SUM_W'(STORE_DEPTH));

   assign new_value = (mode_ff == cpw_pkg::MODE_BLEND) ? mixed : color_ff;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADDR;
         ST_ADDR: state_in = (in_store && (mode_ff == cpw_pkg::MODE_BLEND))
                           ? ST_READ : ST_DONE;
         ST_READ: state_in = ST_MIX;
         ST_MIX:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Capture the command and the address pipeline.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_port.mode;
         x_ff     <= req_port.pos_x;
         y_ff     <= req_port.pos_y;
         color_ff <= req_port.color;
      end
      if (state_ff == ST_MUL) begin
         prod_ff    <= cpw_pkg::PROD_W'(y_mag) * cpw_pkg::PROD_W'(cfg.row_stride);
         clip_ok_ff <= clip_ok;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff   <= addr_sum;
         inside_ff <= in_store;
      end
   end

   // Memory ports: the sweep owns the write port until it ends.
   always_comb begin
      mem_rd_en = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = finish && inside_ff;
         mem_wr_addr = addr_ff[ADDR_W-1:0];
         mem_wr_data = new_value;
      end
   end

   // Report register: hold until taken, load on finish.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_written_ff <= inside_ff;
         rsp_addr_ff    <= inside_ff ? addr_ff[cpw_pkg::PIX_ADDR_W-1:0] : '0;
         rsp_value_ff   <= inside_ff ? new_value : '0;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.written       = rsp_written_ff;
   assign rsp_port.pixel_address = rsp_addr_ff;
   assign rsp_port.stored_value  = rsp_value_ff;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped alpha pixel writer. A short table of
// hand-picked pixel commands is followed by random rasterizer-like traffic
// under seven register settings. Every report is compared against a typed-in
// value or against a behavioral model of the pixel memory kept inside the bench.
// -----------------------------------------------------------------------------
module tb;

   // Index past the last register; a write there must change nothing.
   localparam logic [cpw_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   localparam int CLOCK_HIGH   = 6;
   localparam int CLOCK_LOW    = 6;
   localparam int RESET_CYCLES = 4;
   // A blend is the slowest command to post its report; leave a margin.
   localparam int TAIL_CYCLES  = 16;
   // The post-reset memory sweep alone blocks command acceptance until every
   // word is cleared, so the stall limit must cover it with room to spare.
   localparam int STALL_LIMIT  = 4 * cpw_pkg::STORE_DEPTH_DEF + 20000;
   localparam int NUM_DIRECTED = 20;
   localparam int NUM_PHASES   = 7;

   typedef struct packed {
      logic                           written;
      logic [cpw_pkg::PIX_ADDR_W-1:0] pixel_address;
      logic [cpw_pkg::COLOR_W-1:0]    stored_value;
   } pixel_report_type;

   typedef struct packed {
      logic                        mode;
      logic [cpw_pkg::POS_W-1:0]   pos_x;
      logic [cpw_pkg::POS_W-1:0]   pos_y;
      logic [cpw_pkg::COLOR_W-1:0] color;
      logic                        fixed;    // report typed in below, not predicted
      pixel_report_type            report;
   } directed_cmd_type;

   typedef struct packed {
      logic [cpw_pkg::CSR_DATA_W-1:0] width_data;
      logic [cpw_pkg::CSR_DATA_W-1:0] height_data;
      logic [cpw_pkg::CSR_DATA_W-1:0] stride_data;
      int                             x_lo;
      int                             x_hi;
      int                             y_lo;
      int                             y_hi;
      int                             count;
   } raster_phase_type;

   // --------------------------------------------------------------------------
   // Clock, reset, configuration port and channels
   // --------------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cpw_pkg::CSR_ADDR_W-1:0] paddr;
   logic [cpw_pkg::CSR_DATA_W-1:0] pwdata;
   logic [cpw_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   cpw_req_if req_if ();
   cpw_rsp_if rsp_if ();

   clipped_alpha_pixel_writer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b0;
      #CLOCK_LOW;
      clock = 1'b1;
      #CLOCK_HIGH;
   end

   // --------------------------------------------------------------------------
   // Bench copy of the block state: registers and the pixel memory. The
   // memory is sparse; an address never written reads as zero, as after the
   // clearing sweep.
   // --------------------------------------------------------------------------
   logic [cpw_pkg::CFG_W-1:0]   frame_width_q;
   logic [cpw_pkg::CFG_W-1:0]   frame_height_q;
   logic [cpw_pkg::CFG_W-1:0]   row_stride_q;
   logic [cpw_pkg::COLOR_W-1:0] pixel_mem [int unsigned];

   pixel_report_type pending_reports [$];

   int send_idle_pct = 23;
   int recv_idle_pct = 81;
   int error_count   = 0;
   int cmd_count     = 0;
   int report_count  = 0;
   int blend_count   = 0;
   int clip_count    = 0;
   int setting_count = 0;
   int stall_cycles  = 0;

   // Hand-picked commands under the reset registers (1024 x 1024, stride 1024).
   directed_cmd_type directed_cmds [NUM_DIRECTED] = '{
      // opaque write at both corners of the frame
      '{cpw_pkg::MODE_OPAQUE, 16'd0,    16'd0,    32'hFFFF_FFFF, 1'b1,
        '{1'b1, 20'h0_0000, 32'hFFFF_FFFF}},
      '{cpw_pkg::MODE_OPAQUE, 16'd1023, 16'd1023, 32'h1234_5678, 1'b1,
        '{1'b1, 20'hF_FFFF, 32'h1234_5678}},
      // one past the right and bottom edges
      '{cpw_pkg::MODE_OPAQUE, 16'd1024, 16'd0,    32'hDEAD_BEEF, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_BLEND,  16'd0,    16'd1024, 32'hFFAB_CDEF, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      // negative positions: -1 and the most negative coordinate
      '{cpw_pkg::MODE_BLEND,  16'hFFFF, 16'd0,    32'h8080_8080, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_OPAQUE, 16'd0,    16'hFFFF, 32'h0102_0304, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_BLEND,  16'h8000, 16'h8000, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      // most positive coordinate, far beyond the frame
      '{cpw_pkg::MODE_OPAQUE, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      // zero alpha keeps the stored channels, drops stored alpha
      '{cpw_pkg::MODE_BLEND,  16'd0,    16'd0,    32'h00AB_CDEF, 1'b1,
        '{1'b1, 20'h0_0000, 32'h00FF_FFFF}},
      // full alpha takes the new channels
      '{cpw_pkg::MODE_BLEND,  16'd0,    16'd0,    32'hFF12_3456, 1'b1,
        '{1'b1, 20'h0_0000, 32'h0012_3456}},
      '{cpw_pkg::MODE_BLEND,  16'd1,    16'd0,    32'hFFFF_FFFF, 1'b1,
        '{1'b1, 20'h0_0001, 32'h00FF_FFFF}},
      '{cpw_pkg::MODE_OPAQUE, 16'd2,    16'd0,    32'h0000_0000, 1'b1,
        '{1'b1, 20'h0_0002, 32'h0000_0000}},
      '{cpw_pkg::MODE_OPAQUE, 16'd0,    16'd1,    32'hAAAA_AAAA, 1'b1,
        '{1'b1, 20'h0_0400, 32'hAAAA_AAAA}},
      // blends back to back on one pixel read what the last one wrote
      '{cpw_pkg::MODE_BLEND,  16'd5,    16'd5,    32'h80FF_FFFF, 1'b0,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_BLEND,  16'd5,    16'd5,    32'h8000_0000, 1'b0,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_BLEND,  16'd1023, 16'd1023, 32'h7F00_FF80, 1'b0,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_OPAQUE, 16'd3,    16'd3,    32'h5555_5555, 1'b1,
        '{1'b1, 20'h0_0C03, 32'h5555_5555}},
      '{cpw_pkg::MODE_BLEND,  16'd3,    16'd3,    32'h40AA_55AA, 1'b0,
        '{1'b0, 20'h0_0000, 32'h0000_0000}},
      '{cpw_pkg::MODE_OPAQUE, 16'd1023, 16'd0,    32'h0102_0304, 1'b1,
        '{1'b1, 20'h0_03FF, 32'h0102_0304}},
      '{cpw_pkg::MODE_BLEND,  16'd0,    16'd1023, 32'hC0C0_C0C0, 1'b0,
        '{1'b0, 20'h0_0000, 32'h0000_0000}}
   };

   // Register settings for the random part, with the coordinate window that
   // most commands fall into. Upper data bits carry junk where the register
   // must drop them.
   raster_phase_type raster_phases [NUM_PHASES] = '{
      // reset values, window straddling the bottom edge
      '{32'd1024,      32'd1024,      32'd1024,      -2,   1025, 1018, 1025, 400},
      // small frame: dense reuse, many blends on written pixels
      '{32'd16,        32'd8,         32'd16,        -3,   19,   -3,   11,   300},
      // single pixel frame, zero stride
      '{32'd1,         32'd1,         32'd0,         -2,   2,    -2,   2,    150},
      // empty frame: everything clips
      '{32'd0,         32'd0,         32'd5,         -2,   4,    -2,   4,    100},
      // all registers at 2047: side limit and addresses past the memory
      '{32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F7FF, 1000, 1030, 500,  520,  250},
      // stride 1: rows overlap in memory
      '{32'd1024,      32'd1024,      32'd1,         0,    40,   0,    40,   250},
      '{32'd40,        32'd30,        32'd1024,      -5,   45,   -5,   35,   450}
   };

   // --------------------------------------------------------------------------
   // Pixel prediction
   // --------------------------------------------------------------------------
   function automatic logic [cpw_pkg::CHAN_W-1:0] mix_channel(
         logic [cpw_pkg::CHAN_W-1:0] old_c,
         logic [cpw_pkg::CHAN_W-1:0] new_c,
         logic [cpw_pkg::CHAN_W-1:0] alpha);
      int unsigned o;
      int unsigned n;
      int unsigned a;
      o = 32'(old_c);
      n = 32'(new_c);
      a = 32'(alpha);
      return cpw_pkg::CHAN_W'((o * (255 - a) + n * a) / 255);
   endfunction

   function automatic logic [cpw_pkg::COLOR_W-1:0] blend_pixel(
         logic [cpw_pkg::COLOR_W-1:0] old_px,
         logic [cpw_pkg::COLOR_W-1:0] color);
      logic [cpw_pkg::CHAN_W-1:0] alpha;
      alpha = color[31:24];
      // stored alpha is always zero after a blend
      return {8'h00,
              mix_channel(old_px[23:16], color[23:16], alpha),
              mix_channel(old_px[15:8],  color[15:8],  alpha),
              mix_channel(old_px[7:0],   color[7:0],   alpha)};
   endfunction

   // Work out the report of one command and update the bench pixel memory.
   function automatic pixel_report_type predict_pixel_write(
         logic mode,
         logic [cpw_pkg::POS_W-1:0] pos_x,
         logic [cpw_pkg::POS_W-1:0] pos_y,
         logic [cpw_pkg::COLOR_W-1:0] color);
      pixel_report_type            rep;
      int                          xi;
      int                          yi;
      int                          wi;
      int                          hi;
      longint                      lin;
      logic [cpw_pkg::COLOR_W-1:0] old_px;
      logic [cpw_pkg::COLOR_W-1:0] new_px;
      rep = '0;
      xi  = int'($signed(pos_x));
      yi  = int'($signed(pos_y));
      wi  = int'(frame_width_q);
      hi  = int'(frame_height_q);
      if (xi < 0 || yi < 0)
         return rep;
      if (xi >= wi || yi >= hi || xi >= cpw_pkg::MAX_SIDE_DEF || yi >= cpw_pkg::MAX_SIDE_DEF)
         return rep;
      lin = longint'(yi) * longint'(row_stride_q) + longint'(xi);
      if (lin >= cpw_pkg::STORE_DEPTH_DEF)
         return rep;
      old_px = pixel_mem.exists(int'(lin)) ? pixel_mem[int'(lin)] : '0;
      new_px = (mode == cpw_pkg::MODE_BLEND) ? blend_pixel(old_px, color) : color;
      pixel_mem[int'(lin)] = new_px;
      rep.written       = 1'b1;
      rep.pixel_address = lin[cpw_pkg::PIX_ADDR_W-1:0];
      rep.stored_value  = new_px;
      return rep;
   endfunction

   // --------------------------------------------------------------------------
   // Random picks
   // --------------------------------------------------------------------------
   // Mostly inside the window; some full-range noise toggles every bit.
   function automatic logic [cpw_pkg::POS_W-1:0] pick_coord(int lo, int hi);
      int v;
      if ($urandom_range(99) < 15)
         return cpw_pkg::POS_W'($urandom);
      v = lo + int'($urandom_range(hi - lo));
      return v[cpw_pkg::POS_W-1:0];
   endfunction

   // Bias alpha toward its extremes now and then.
   function automatic logic [cpw_pkg::COLOR_W-1:0] pick_color();
      logic [cpw_pkg::COLOR_W-1:0] c;
      c = $urandom;
      case ($urandom_range(9))
         0: c[31:24] = 8'h00;
         1: c[31:24] = 8'hFF;
         default: ;
      endcase
      return c;
   endfunction

   // --------------------------------------------------------------------------
   // Drivers. Every task is entered right after a rising edge and returns
   // right after one, so each signal gets one nonblocking update per step.
   // --------------------------------------------------------------------------
   // Write one register: setup cycle, access cycle, then an idle cycle so
   // that psel is not dropped and raised again in the same step.
   task automatic csr_write(logic [cpw_pkg::REG_IDX_W-1:0] idx,
                            logic [cpw_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // the register takes the value at this edge
      case (idx)
         cpw_pkg::REG_FRAME_WIDTH:  frame_width_q  = data[cpw_pkg::CFG_W-1:0];
         cpw_pkg::REG_FRAME_HEIGHT: frame_height_q = data[cpw_pkg::CFG_W-1:0];
         cpw_pkg::REG_ROW_STRIDE:   row_stride_q   = data[cpw_pkg::CFG_W-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one pixel command, then record its expected report once taken.
   task automatic send_pixel(logic mode, logic [cpw_pkg::POS_W-1:0] pos_x,
                             logic [cpw_pkg::POS_W-1:0] pos_y,
                             logic [cpw_pkg::COLOR_W-1:0] color, logic fixed,
                             pixel_report_type fixed_rep);
      pixel_report_type rep;
      // Stall schedule: sender light and receiver heavy, then swapped, then none.
      if (cmd_count < 640) begin
         send_idle_pct = 23;
         recv_idle_pct = 81;
      end else if (cmd_count < 1280) begin
         send_idle_pct = 81;
         recv_idle_pct = 23;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.pos_x <= pos_x;
      req_if.pos_y <= pos_y;
      req_if.color <= color;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge: advance the bench copy of the memory
      rep = predict_pixel_write(mode, pos_x, pos_y, color);
      if (fixed)
         rep = fixed_rep;
      pending_reports.push_back(rep);
      cmd_count++;
      if (mode == cpw_pkg::MODE_BLEND)
         blend_count++;
      if (!rep.written)
         clip_count++;
   endtask

   // Hold off the sender until every outstanding report has come back.
   task automatic drain_reports();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Receiver: random back-pressure on the report channel.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // --------------------------------------------------------------------------
   // Report checker: compare each accepted report with the oldest prediction.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : report_check
      pixel_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         report_count++;
         if (pending_reports.size() == 0) begin
            $error("report with no command outstanding: written %0d addr %h value %h",
                   rsp_if.written, rsp_if.pixel_address, rsp_if.stored_value);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_if.written !== want.written) begin
               $error("written: expected %0d, actual %0d", want.written, rsp_if.written);
               error_count++;
            end
            if (rsp_if.pixel_address !== want.pixel_address) begin
               $error("pixel_address: expected %h, actual %h",
                      want.pixel_address, rsp_if.pixel_address);
               error_count++;
            end
            if (rsp_if.stored_value !== want.stored_value) begin
               $error("stored_value: expected %h, actual %h",
                      want.stored_value, rsp_if.stored_value);
               error_count++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: end the run if no transaction moves on either channel for
   // too long.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d reports outstanding",
                  stall_cycles, pending_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      // Drive every input to a known value before the first edge.
      reset        = 1'b1;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_if.valid = 1'b0;
      req_if.mode  = cpw_pkg::MODE_OPAQUE;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.color = '0;
      frame_width_q  = cpw_pkg::CFG_RESET;
      frame_height_q = cpw_pkg::CFG_RESET;
      row_stride_q   = cpw_pkg::CFG_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed commands under the reset registers. The block sweeps its
      // memory first, so the first one waits until the sweep is done.
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_pixel(directed_cmds[i].mode, directed_cmds[i].pos_x, directed_cmds[i].pos_y,
                    directed_cmds[i].color, directed_cmds[i].fixed,
                    directed_cmds[i].report);

      // Random traffic, one register setting per phase. Drain before each
      // reprogramming so the block is idle when its registers change.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_reports();
         @(posedge clock);
         // Hit the unmapped index before and after the writes; the last setting must stay intact.
         if (p == NUM_PHASES - 1)
            csr_write(REG_UNMAPPED, $urandom);
         csr_write(cpw_pkg::REG_FRAME_WIDTH,  raster_phases[p].width_data);
         csr_write(cpw_pkg::REG_FRAME_HEIGHT, raster_phases[p].height_data);
         csr_write(cpw_pkg::REG_ROW_STRIDE,   raster_phases[p].stride_data);
         if (p == NUM_PHASES - 1)
            csr_write(REG_UNMAPPED, $urandom);
         setting_count++;
         for (int n = 0; n < raster_phases[p].count; n++)
            send_pixel(logic'($urandom_range(1)),
                       pick_coord(raster_phases[p].x_lo, raster_phases[p].x_hi),
                       pick_coord(raster_phases[p].y_lo, raster_phases[p].y_hi),
                       pick_color(), 1'b0, '0);
      end

      // Wait out every report, then a tail wait for stray ones.
      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d reports never arrived", pending_reports.size());
         error_count++;
      end

      $display("Covered %0d pixel commands (%0d blends, %0d clipped) under %0d settings,",
               cmd_count, blend_count, clip_count, setting_count + 1);
      $display("with stalls on either side and none; %0d reports checked, %0d mismatches.",
               report_count, error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
